// ===== hdl/ptt_pkg.sv =====
// Shared types and codes for the periodic timer table.
`default_nettype none
package ptt_pkg;

   localparam int TIMER_SLOTS_DEF = 16;

   // most expiries reported for one tick
   localparam int RESULT_CAP = 16;
   localparam int REP_W = $clog2(RESULT_CAP + 1);

   localparam int ID_W = 31;
   localparam int IVL_W = 31;
   localparam int TGT_W = 8;
   localparam int MSG_W = 32;

   // request kinds
   localparam logic [1:0] KIND_ADD = 2'd0;
   localparam logic [1:0] KIND_DEL = 2'd1;
   localparam logic [1:0] KIND_RST = 2'd2;
   localparam logic [1:0] KIND_TICK = 2'd3;

   // result status codes
   localparam logic [2:0] ST_DONE = 3'd0;
   localparam logic [2:0] ST_FULL = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND = 3'd2;
   localparam logic [2:0] ST_IN_USE = 3'd3;
   localparam logic [2:0] ST_EXPIRY = 3'd4;

   typedef struct packed {
      logic [1:0] kind;
      logic [ID_W-1:0] timer_id;
      logic [IVL_W-1:0] interval;
      logic repeat_req;
      logic [TGT_W-1:0] target;
      logic [MSG_W-1:0] message_tag;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [ID_W-1:0] result_id;
      logic [TGT_W-1:0] fired_target;
      logic [MSG_W-1:0] fired_message;
      logic last;
   } rsp_type;

   // everything in a slot except its running count
   typedef struct packed {
      logic [ID_W-1:0] id;
      logic [IVL_W-1:0] interval;
      logic repeat_flag;
      logic [TGT_W-1:0] target;
      logic [MSG_W-1:0] message;
   } slot_info_type;

endpackage
`default_nettype wire

// ===== hdl/ptt_slot_mem.sv =====
// Slot storage: count memory and info memory, shared write address, registered read.
`default_nettype none
module ptt_slot_mem #(
   parameter int TIMER_SLOTS = ptt_pkg::TIMER_SLOTS_DEF,
   localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1
) (
   input  wire logic                         clock,
   input  wire logic                         rd_en,
   input  wire logic [IDX_W-1:0]             rd_addr,
   output      logic [ptt_pkg::IVL_W-1:0]    rd_count,
   output      ptt_pkg::slot_info_type       rd_info,
   input  wire logic [IDX_W-1:0]             wr_addr,
   input  wire logic                         cnt_we,
   input  wire logic [ptt_pkg::IVL_W-1:0]    cnt_wdata,
   input  wire logic                         info_we,
   input  wire ptt_pkg::slot_info_type       info_wdata
);

   logic [ptt_pkg::IVL_W-1:0] cnt_mem [TIMER_SLOTS];
   ptt_pkg::slot_info_type info_mem [TIMER_SLOTS];

   logic [ptt_pkg::IVL_W-1:0] rd_count_ff;
   ptt_pkg::slot_info_type rd_info_ff;

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[wr_addr] <= cnt_wdata;
      end
      if (info_we) begin
         info_mem[wr_addr] <= info_wdata;
      end
      // read data holds while the scan is stalled
      if (rd_en) begin
         rd_count_ff <= cnt_mem[rd_addr];
         rd_info_ff <= info_mem[rd_addr];
      end
   end

   assign rd_count = rd_count_ff;
   assign rd_info = rd_info_ff;

endmodule
`default_nettype wire

// ===== hdl/ptt_ctrl.sv =====
// Request sequencer: slot scan, table updates, expiry hold buffer and result register.
`default_nettype none
module ptt_ctrl #(
   parameter int TIMER_SLOTS = ptt_pkg::TIMER_SLOTS_DEF,
   localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_ready,
   input  wire ptt_pkg::req_type             req,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   output      ptt_pkg::rsp_type             rsp,
   output      logic                         rd_en,
   output      logic [IDX_W-1:0]             rd_addr,
   input  wire logic [ptt_pkg::IVL_W-1:0]    rd_count,
   input  wire ptt_pkg::slot_info_type       rd_info,
   output      logic [IDX_W-1:0]             wr_addr,
   output      logic                         cnt_we,
   output      logic [ptt_pkg::IVL_W-1:0]    cnt_wdata,
   output      logic                         info_we,
   output      ptt_pkg::slot_info_type       info_wdata
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_SLOTS - 1);
   localparam logic [ptt_pkg::ID_W-1:0] ID_MAX = '1;

   logic [1:0] state_ff, state_in;
   ptt_pkg::req_type req_ff, req_in;
   logic [ptt_pkg::ID_W-1:0] last_id_ff, last_id_in;
   logic [TIMER_SLOTS-1:0] slot_vld_ff, slot_vld_in;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic issue_done_ff, issue_done_in;
   logic eval_vld_ff, eval_vld_in;
   logic [IDX_W-1:0] eval_idx_ff, eval_idx_in;

   logic found_ff, found_in;
   logic [IDX_W-1:0] found_idx_ff, found_idx_in;
   logic free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;

   logic hold_vld_ff, hold_vld_in;
   ptt_pkg::rsp_type hold_ff, hold_in;
   logic [ptt_pkg::REP_W-1:0] rep_cnt_ff, rep_cnt_in;

   logic out_vld_ff, out_vld_in;
   ptt_pkg::rsp_type out_ff, out_in;

   logic out_free;
   logic accept;
   logic [ptt_pkg::ID_W-1:0] next_id;
   logic e_valid;
   logic [ptt_pkg::IVL_W-1:0] cnt_inc;
   logic expire;
   logic report;
   logic is_tick;
   logic stall;
   logic issuing;
   ptt_pkg::rsp_type fin_rsp;
   ptt_pkg::rsp_type exp_rsp;

   assign out_free = !out_vld_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign accept = req_valid && req_ready;
   assign next_id = (last_id_ff == ID_MAX) ? ptt_pkg::ID_W'(1) : last_id_ff + 1'b1;

   assign e_valid = slot_vld_ff[eval_idx_ff];
   assign cnt_inc = rd_count + 1'b1;
   assign is_tick = (req_ff.kind == ptt_pkg::KIND_TICK);
   assign expire = e_valid && (rd_info.interval != '0) && (cnt_inc == rd_info.interval);
   assign report = expire && (rep_cnt_ff < ptt_pkg::REP_W'(ptt_pkg::RESULT_CAP));
   // a second expiry needs the held one pushed out first
   assign stall = (state_ff == S_SCAN) && eval_vld_ff && is_tick && report
                  && hold_vld_ff && !out_free;
   assign issuing = (state_ff == S_SCAN) && !issue_done_ff && !stall;

   assign rd_en = issuing;
   assign rd_addr = idx_ff;

   always_comb begin
      exp_rsp = '0;
      exp_rsp.status = ptt_pkg::ST_EXPIRY;
      exp_rsp.result_id = rd_info.id;
      exp_rsp.fired_target = rd_info.target;
      exp_rsp.fired_message = rd_info.message;
      exp_rsp.last = 1'b0;
   end

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      last_id_in = last_id_ff;
      slot_vld_in = slot_vld_ff;
      idx_in = idx_ff;
      issue_done_in = issue_done_ff;
      eval_vld_in = eval_vld_ff;
      eval_idx_in = eval_idx_ff;
      found_in = found_ff;
      found_idx_in = found_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in = free_idx_ff;
      hold_vld_in = hold_vld_ff;
      hold_in = hold_ff;
      rep_cnt_in = rep_cnt_ff;
      out_vld_in = out_vld_ff && !rsp_ready;
      out_in = out_ff;
      wr_addr = eval_idx_ff;
      cnt_we = 1'b0;
      cnt_wdata = '0;
      info_we = 1'b0;
      info_wdata = '0;
      fin_rsp = '0;
      fin_rsp.last = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in = req;
               idx_in = '0;
               issue_done_in = 1'b0;
               eval_vld_in = 1'b0;
               found_in = 1'b0;
               free_found_in = 1'b0;
               hold_vld_in = 1'b0;
               rep_cnt_in = '0;
               if (req.kind == ptt_pkg::KIND_ADD) begin
                  last_id_in = next_id;
               end
               if ((req.kind == ptt_pkg::KIND_DEL || req.kind == ptt_pkg::KIND_RST)
                   && req.timer_id == '0) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            if (!stall) begin
               eval_vld_in = issuing;
               eval_idx_in = idx_ff;
               if (issuing) begin
                  if (idx_ff == LAST_IDX) begin
                     issue_done_in = 1'b1;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
               if (eval_vld_ff) begin
                  case (req_ff.kind)
                     ptt_pkg::KIND_ADD: begin
                        if (e_valid && rd_info.id == last_id_ff) begin
                           found_in = 1'b1;
                        end
                        if (!e_valid && !free_found_ff) begin
                           free_found_in = 1'b1;
                           free_idx_in = eval_idx_ff;
                        end
                     end
                     ptt_pkg::KIND_DEL, ptt_pkg::KIND_RST: begin
                        if (e_valid && rd_info.id == req_ff.timer_id && !found_ff) begin
                           found_in = 1'b1;
                           found_idx_in = eval_idx_ff;
                        end
                     end
                     default: begin
                        // tick: step every live timer with a nonzero interval
                        if (e_valid && rd_info.interval != '0) begin
                           cnt_we = 1'b1;
                           cnt_wdata = expire ? '0 : cnt_inc;
                           if (expire && !rd_info.repeat_flag) begin
                              slot_vld_in[eval_idx_ff] = 1'b0;
                           end
                        end
                        if (report) begin
                           if (hold_vld_ff) begin
                              out_vld_in = 1'b1;
                              out_in = hold_ff;
                           end
                           hold_vld_in = 1'b1;
                           hold_in = exp_rsp;
                           rep_cnt_in = rep_cnt_ff + 1'b1;
                        end
                     end
                  endcase
                  if (eval_idx_ff == LAST_IDX) begin
                     state_in = S_FINISH;
                  end
               end
            end
         end

         S_FINISH: begin
            case (req_ff.kind)
               ptt_pkg::KIND_ADD: begin
                  fin_rsp.result_id = last_id_ff;
                  if (found_ff) begin
                     fin_rsp.status = ptt_pkg::ST_IN_USE;
                  end else if (!free_found_ff) begin
                     fin_rsp.status = ptt_pkg::ST_FULL;
                  end else begin
                     fin_rsp.status = ptt_pkg::ST_DONE;
                  end
                  if (out_free) begin
                     out_vld_in = 1'b1;
                     out_in = fin_rsp;
                     state_in = S_IDLE;
                     if (!found_ff && free_found_ff) begin
                        wr_addr = free_idx_ff;
                        cnt_we = 1'b1;
                        cnt_wdata = '0;
                        info_we = 1'b1;
                        info_wdata.id = last_id_ff;
                        info_wdata.interval = req_ff.interval;
                        info_wdata.repeat_flag = req_ff.repeat_req;
                        info_wdata.target = req_ff.target;
                        info_wdata.message = req_ff.message_tag;
                        slot_vld_in[free_idx_ff] = 1'b1;
                     end
                  end
               end
               ptt_pkg::KIND_DEL, ptt_pkg::KIND_RST: begin
                  fin_rsp.result_id = req_ff.timer_id;
                  if (req_ff.timer_id == '0 || found_ff) begin
                     fin_rsp.status = ptt_pkg::ST_DONE;
                  end else begin
                     fin_rsp.status = ptt_pkg::ST_NOT_FOUND;
                  end
                  if (out_free) begin
                     out_vld_in = 1'b1;
                     out_in = fin_rsp;
                     state_in = S_IDLE;
                     if (req_ff.timer_id != '0 && found_ff) begin
                        if (req_ff.kind == ptt_pkg::KIND_DEL) begin
                           slot_vld_in[found_idx_ff] = 1'b0;
                        end else begin
                           wr_addr = found_idx_ff;
                           cnt_we = 1'b1;
                           cnt_wdata = '0;
                        end
                     end
                  end
               end
               default: begin
                  // tick: the held expiry, if any, closes the burst
                  if (!hold_vld_ff) begin
                     state_in = S_IDLE;
                  end else if (out_free) begin
                     out_vld_in = 1'b1;
                     out_in = hold_ff;
                     out_in.last = 1'b1;
                     hold_vld_in = 1'b0;
                     state_in = S_IDLE;
                  end
               end
            endcase
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         last_id_ff <= '0;
         slot_vld_ff <= '0;
         issue_done_ff <= 1'b0;
         eval_vld_ff <= 1'b0;
         found_ff <= 1'b0;
         free_found_ff <= 1'b0;
         hold_vld_ff <= 1'b0;
         rep_cnt_ff <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_id_ff <= last_id_in;
         slot_vld_ff <= slot_vld_in;
         issue_done_ff <= issue_done_in;
         eval_vld_ff <= eval_vld_in;
         found_ff <= found_in;
         free_found_ff <= free_found_in;
         hold_vld_ff <= hold_vld_in;
         rep_cnt_ff <= rep_cnt_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      idx_ff <= idx_in;
      eval_idx_ff <= eval_idx_in;
      found_idx_ff <= found_idx_in;
      free_idx_ff <= free_idx_in;
      hold_ff <= hold_in;
      out_ff <= out_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp = out_ff;

endmodule
`default_nettype wire

// ===== hdl/periodic_timer_table_core.sv =====
// Top level of the periodic timer table: stream ports, field packing, sequencer and slot memory.
// Ordering: add, delete and reset answer from the finish state after a scan of every slot
//   (delete or reset of id 0 skips the scan); a tick's last expiry leaves from the finish state.
// Requests: one at a time, a new one taken only when idle; the scan reads one slot per cycle
//   unless stalled, and result back-pressure stalls the scan and the finish state.
// Reset: synchronous, active high; clears slot valid bits, id counter and control, not memory.
`default_nettype none
module periodic_timer_table_core #(
   parameter int TIMER_SLOTS = ptt_pkg::TIMER_SLOTS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // request channel
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   // tdata, low bit up: timer_id[30:0], interval[61:31], repeat_req[62],
   //   target[70:63], message_tag[102:71], zero pad[103]
   input  wire logic [103:0] req_tdata,
   // tuser: kind[1:0]
   input  wire logic [1:0]   req_tuser,
   // response channel
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   // tdata, low bit up: status[2:0], result_id[33:3], fired_target[41:34],
   //   fired_message[73:42], zero pad[79:74]
   output      logic [79:0]  rsp_tdata,
   // tlast: last result of the transaction that caused it
   output      logic         rsp_tlast
);

   localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

   ptt_pkg::req_type req;
   ptt_pkg::rsp_type rsp;

   logic rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [ptt_pkg::IVL_W-1:0] rd_count;
   ptt_pkg::slot_info_type rd_info;
   logic [IDX_W-1:0] wr_addr;
   logic cnt_we;
   logic [ptt_pkg::IVL_W-1:0] cnt_wdata;
   logic info_we;
   ptt_pkg::slot_info_type info_wdata;

   // unpack the request; the top pad bit of tdata carries nothing
   always_comb begin
      req.kind = req_tuser;
      req.timer_id = req_tdata[30:0];
      req.interval = req_tdata[61:31];
      req.repeat_req = req_tdata[62];
      req.target = req_tdata[70:63];
      req.message_tag = req_tdata[102:71];
   end

   // the pad bit is ignored by design
   logic unused_pad;
   assign unused_pad = req_tdata[103];

   ptt_ctrl #(
      .TIMER_SLOTS(TIMER_SLOTS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req        (req),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_count   (rd_count),
      .rd_info    (rd_info),
      .wr_addr    (wr_addr),
      .cnt_we     (cnt_we),
      .cnt_wdata  (cnt_wdata),
      .info_we    (info_we),
      .info_wdata (info_wdata)
   );

   ptt_slot_mem #(
      .TIMER_SLOTS(TIMER_SLOTS)
   ) u_slot_mem (
      .clock      (clock),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_count   (rd_count),
      .rd_info    (rd_info),
      .wr_addr    (wr_addr),
      .cnt_we     (cnt_we),
      .cnt_wdata  (cnt_wdata),
      .info_we    (info_we),
      .info_wdata (info_wdata)
   );

   // pack the response, zero pad on top
   assign rsp_tdata = {6'b0, rsp.fired_message, rsp.fired_target, rsp.result_id, rsp.status};
   assign rsp_tlast = rsp.last;

endmodule
`default_nettype wire

// ===== dv/periodic_timer_table_core_test.sv =====
// Self-checking testbench for the periodic timer table: stream driver, shadow model, checker.
`default_nettype none
module periodic_timer_table_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TIMER_SLOTS = ptt_pkg::TIMER_SLOTS_DEF;
   // one request per scan of the slot memory, plus margin for the drain at the end
   localparam int DRAIN_CYCLES = 2 * TIMER_SLOTS + 8;
   localparam int RANDOM_PER_PHASE = 60;

   // ---------------------------------------------------------------- clock, reset, ports
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // tdata, low bit up: timer_id, interval, repeat_req, target, message_tag, zero pad
   logic [103:0] req_tdata = '0;
   // tuser: kind
   logic [1:0]   req_tuser = ptt_pkg::KIND_TICK;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // tdata, low bit up: status, result_id, fired_target, fired_message, zero pad
   logic [79:0]  rsp_tdata;
   logic         rsp_tlast;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   periodic_timer_table_core #(
      .TIMER_SLOTS(TIMER_SLOTS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   // ---------------------------------------------------------------- bookkeeping
   ptt_pkg::req_type queued_requests[$];   // stimulus not yet on the bus
   ptt_pkg::rsp_type due_results[$];       // results owed by the block, oldest first
   ptt_pkg::req_type on_bus;               // request currently presented on req_*
   logic    req_taken = 1'b0;     // on_bus was accepted at the last rising edge
   int      mismatch_count = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      adds_issued = 0;      // ids handed out so far, used to aim deletes and resets

   // shadow copy of the timer table
   logic                      live [TIMER_SLOTS] = '{default: 1'b0};
   logic [ptt_pkg::ID_W-1:0]  tmr_id [TIMER_SLOTS];
   logic [ptt_pkg::IVL_W-1:0] tmr_interval [TIMER_SLOTS];
   logic [ptt_pkg::IVL_W-1:0] tmr_count [TIMER_SLOTS];
   logic                      tmr_periodic [TIMER_SLOTS];
   logic [ptt_pkg::TGT_W-1:0] tmr_target [TIMER_SLOTS];
   logic [ptt_pkg::MSG_W-1:0] tmr_message [TIMER_SLOTS];
   logic [ptt_pkg::ID_W-1:0]  id_counter = '0;

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      $display("ERROR @%0t: %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
      mismatch_count++;
   endtask

   function automatic int find_live(input logic [ptt_pkg::ID_W-1:0] id);
      for (int s = 0; s < TIMER_SLOTS; s++) begin
         if (live[s] && tmr_id[s] == id) return s;
      end
      return -1;
   endfunction

   // Advances the shadow table by one request and queues the results it owes.
   task automatic apply_request(input ptt_pkg::req_type r);
      int      found;
      int      free_idx;
      int      n;
      ptt_pkg::rsp_type one;
      ptt_pkg::rsp_type fired [ptt_pkg::RESULT_CAP];
      logic [ptt_pkg::ID_W-1:0] fresh;
      one = '0;
      n = 0;
      case (r.kind)
         ptt_pkg::KIND_ADD: begin
            // counter steps even when the add fails; never hands out 0
            fresh = id_counter + 1'b1;
            if (fresh == '0) fresh = ptt_pkg::ID_W'(1);
            id_counter = fresh;
            one.result_id = fresh;
            one.last = 1'b1;
            if (find_live(fresh) >= 0) begin
               one.status = ptt_pkg::ST_IN_USE;
            end else begin
               free_idx = -1;
               for (int s = 0; s < TIMER_SLOTS; s++) begin
                  if (!live[s] && free_idx < 0) free_idx = s;
               end
               if (free_idx < 0) begin
                  one.status = ptt_pkg::ST_FULL;
               end else begin
                  live[free_idx] = 1'b1;
                  tmr_id[free_idx] = fresh;
                  tmr_interval[free_idx] = r.interval;
                  tmr_count[free_idx] = '0;
                  tmr_periodic[free_idx] = r.repeat_req;
                  tmr_target[free_idx] = r.target;
                  tmr_message[free_idx] = r.message_tag;
                  one.status = ptt_pkg::ST_DONE;
               end
            end
            due_results.push_back(one);
         end
         ptt_pkg::KIND_DEL, ptt_pkg::KIND_RST: begin
            one.last = 1'b1;
            one.status = ptt_pkg::ST_DONE;
            if (r.timer_id != '0) begin
               one.result_id = r.timer_id;
               found = find_live(r.timer_id);
               if (found < 0) one.status = ptt_pkg::ST_NOT_FOUND;
               else if (r.kind == ptt_pkg::KIND_DEL) live[found] = 1'b0;
               else tmr_count[found] = '0;
            end
            due_results.push_back(one);
         end
         default: begin
            // tick: slot order, zero interval never counts, report capped
            for (int s = 0; s < TIMER_SLOTS; s++) begin
               if (live[s] && tmr_interval[s] != '0) begin
                  tmr_count[s] = tmr_count[s] + 1'b1;
                  if (tmr_count[s] == tmr_interval[s]) begin
                     if (n < ptt_pkg::RESULT_CAP) begin
                        fired[n] = '0;
                        fired[n].status = ptt_pkg::ST_EXPIRY;
                        fired[n].result_id = tmr_id[s];
                        fired[n].fired_target = tmr_target[s];
                        fired[n].fired_message = tmr_message[s];
                        n++;
                     end
                     if (tmr_periodic[s]) tmr_count[s] = '0;
                     else live[s] = 1'b0;
                  end
               end
            end
            for (int k = 0; k < n; k++) begin
               fired[k].last = (k == n - 1);
               due_results.push_back(fired[k]);
            end
         end
      endcase
   endtask

   // ---------------------------------------------------------------- stimulus helpers
   function automatic ptt_pkg::req_type compose_request(
         input logic [1:0] kind,
         input logic [ptt_pkg::ID_W-1:0] id,
         input logic [ptt_pkg::IVL_W-1:0] ivl,
         input logic rep,
         input logic [ptt_pkg::TGT_W-1:0] tgt,
         input logic [ptt_pkg::MSG_W-1:0] msg);
      ptt_pkg::req_type r;
      r.kind = kind;
      r.timer_id = id;
      r.interval = ivl;
      r.repeat_req = rep;
      r.target = tgt;
      r.message_tag = msg;
      return r;
   endfunction

   task automatic queue_request(input ptt_pkg::req_type r);
      if (r.kind == ptt_pkg::KIND_ADD) adds_issued++;
      queued_requests.push_back(r);
   endtask

   // Mostly ids handed out recently (live or just freed), some noise and id 0.
   function automatic logic [ptt_pkg::ID_W-1:0] pick_timer_id();
      int          roll;
      int          lo;
      logic [31:0] raw;
      roll = $urandom_range(99);
      raw = $urandom();
      if (roll < 10) return '0;
      if (roll < 25 || adds_issued == 0) return raw[ptt_pkg::ID_W-1:0];
      lo = (adds_issued > 20) ? adds_issued - 20 : 1;
      return ptt_pkg::ID_W'($urandom_range(adds_issued, lo));
   endfunction

   function automatic ptt_pkg::req_type random_request();
      int          roll;
      int          ivl_roll;
      logic [1:0]  kind;
      logic [31:0] raw_ivl;
      logic [31:0] raw_id;
      logic [ptt_pkg::IVL_W-1:0] ivl;
      roll = $urandom_range(99);
      ivl_roll = $urandom_range(99);
      raw_ivl = $urandom();
      raw_id = $urandom();
      if (roll < 35) kind = ptt_pkg::KIND_ADD;
      else if (roll < 52) kind = ptt_pkg::KIND_DEL;
      else if (roll < 65) kind = ptt_pkg::KIND_RST;
      else kind = ptt_pkg::KIND_TICK;
      // short intervals so timers fire; some zero, some far beyond the run
      if (ivl_roll < 70) ivl = ptt_pkg::IVL_W'($urandom_range(6, 1));
      else if (ivl_roll < 80) ivl = '0;
      else ivl = raw_ivl[ptt_pkg::IVL_W-1:0];
      return compose_request(kind,
                             (kind == ptt_pkg::KIND_DEL || kind == ptt_pkg::KIND_RST)
                                ? pick_timer_id() : raw_id[ptt_pkg::ID_W-1:0],
                             ivl, 1'($urandom_range(1)), ptt_pkg::TGT_W'($urandom()),
                             $urandom());
   endfunction

   // ---------------------------------------------------------------- driver
   // Presents the next queued request at the falling edge once the previous one has
   // been taken; random gaps per send_idle_pct.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_taken) begin
            if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               on_bus <= queued_requests[0];
               req_tdata <= {1'b0, queued_requests[0].message_tag, queued_requests[0].target,
                             queued_requests[0].repeat_req, queued_requests[0].interval,
                             queued_requests[0].timer_id};
               req_tuser <= queued_requests[0].kind;
               void'(queued_requests.pop_front());
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------- monitor and checker
   // Accepted requests feed the shadow table; accepted results are matched in order.
   always @(posedge clock) begin
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) apply_request(on_bus);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_results.size() == 0) begin
            report_mismatch("result transaction with nothing outstanding", '0,
                            rsp_tdata[63:0]);
         end else begin
            if (rsp_tdata[2:0] != due_results[0].status)
               report_mismatch("status", 64'(due_results[0].status), 64'(rsp_tdata[2:0]));
            if (rsp_tdata[33:3] != due_results[0].result_id)
               report_mismatch("result_id", 64'(due_results[0].result_id),
                               64'(rsp_tdata[33:3]));
            if (rsp_tdata[41:34] != due_results[0].fired_target)
               report_mismatch("fired_target", 64'(due_results[0].fired_target),
                               64'(rsp_tdata[41:34]));
            if (rsp_tdata[73:42] != due_results[0].fired_message)
               report_mismatch("fired_message", 64'(due_results[0].fired_message),
                               64'(rsp_tdata[73:42]));
            if (rsp_tlast != due_results[0].last)
               report_mismatch("tlast", 64'(due_results[0].last), 64'(rsp_tlast));
            void'(due_results.pop_front());
         end
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         // sender busy / receiver choked, then swapped, then full rate both ways
         send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 60 : 0;
         recv_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 8 : 0;

         if (phase == 0) begin
            // empty table tick: no result at all
            queue_request(compose_request(ptt_pkg::KIND_TICK, '0, '0, 1'b0, '0, '0));
            // id zero is a no-op for delete and reset
            queue_request(compose_request(ptt_pkg::KIND_DEL, '0, '1, 1'b1, '1, '1));
            queue_request(compose_request(ptt_pkg::KIND_RST, '0, '0, 1'b0, '0, '0));
            // unknown ids
            queue_request(compose_request(ptt_pkg::KIND_DEL, '1, '0, 1'b0, '0, '0));
            queue_request(compose_request(ptt_pkg::KIND_RST, 31'd5, '0, 1'b0, '0, '0));
            // id 1: zero interval, stays live, never fires
            queue_request(compose_request(ptt_pkg::KIND_ADD, '1, '0, 1'b1, '1, '1));
            // id 2: widest interval, effectively never fires
            queue_request(compose_request(ptt_pkg::KIND_ADD, '0, '1, 1'b0, '0, '0));
            // id 3: periodic every tick; id 4: one-shot after two ticks
            queue_request(compose_request(ptt_pkg::KIND_ADD, '0, 31'd1, 1'b1, 8'hA5,
                                          32'hDEADBEEF));
            queue_request(compose_request(ptt_pkg::KIND_ADD, '0, 31'd2, 1'b0, 8'h5A,
                                          32'h01234567));
            queue_request(compose_request(ptt_pkg::KIND_TICK, '0, '0, 1'b0, '0, '0));
            // reset count of id 4, so it needs two more ticks
            queue_request(compose_request(ptt_pkg::KIND_RST, 31'd4, '0, 1'b0, '0, '0));
            queue_request(compose_request(ptt_pkg::KIND_TICK, '0, '0, 1'b0, '0, '0));
            // ids 3 and 4 both expire, 4 is freed
            queue_request(compose_request(ptt_pkg::KIND_TICK, '0, '0, 1'b0, '0, '0));
            queue_request(compose_request(ptt_pkg::KIND_DEL, 31'd3, '0, 1'b0, '0, '0));
            queue_request(compose_request(ptt_pkg::KIND_DEL, 31'd4, '0, 1'b0, '0, '0));
            // fill the table with every-tick timers, half periodic
            for (int i = 0; i < TIMER_SLOTS - 2; i++) begin
               queue_request(compose_request(ptt_pkg::KIND_ADD, '0, 31'd1, i[0],
                                             ptt_pkg::TGT_W'(i * 17), $urandom()));
            end
            // table full
            queue_request(compose_request(ptt_pkg::KIND_ADD, '0, 31'd3, 1'b1, 8'h11, 32'h22));
            // burst of expiries, one-shots freed
            queue_request(compose_request(ptt_pkg::KIND_TICK, '0, '0, 1'b0, '0, '0));
         end

         repeat (RANDOM_PER_PHASE) queue_request(random_request());

         // drain before the idle pattern changes
         while (queued_requests.size() != 0 || req_tvalid || due_results.size() != 0)
            @(posedge clock);
      end

      // a trailing tick may still be scanning with nothing to report
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && due_results.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #3_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
`default_nettype wire
